[rtl/ffa_pkg.sv]
package ffa_pkg;

    typedef struct packed {
        logic        cmd;
        logic [15:0] alloc_bytes;
        logic [11:0] block_address;
    } t_req;

    typedef struct packed {
        logic [11:0] address;
        logic        fail;
    } t_rsp;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic REG_HEAP_LIMIT = 1'b0;
    localparam logic REG_MIN_GROW   = 1'b1;

    localparam logic [11:0] HEAP_LIMIT_RST = 12'd4095;
    localparam logic [11:0] MIN_GROW_RST   = 12'd1024;

endpackage

[rtl/first_fit_free_list_allocator.sv]
// first fit free-list allocator, one request at a time, headers in a 1r1w memory
// allocate walks the headers from the rover and writes a tail header when the block is split;
//   free walks the headers to the insert point; each arena growth writes a new header and walks
//   the free list to insert it; ready again in the cycle after the response beat is taken
// reset: synchronous active low; clears control, rover, break and config; header
//   memory is not cleared (sentinel built on first request)
module first_fit_free_list_allocator #(
    parameter int unsigned HEAP_UNITS = 4096,
    parameter int unsigned UNIT_BYTES = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  ffa_pkg::t_req    i_req,
    output logic             o_valid,
    input  logic             i_ready,
    output ffa_pkg::t_rsp    o_rsp,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic             i_cfg_index,
    input  logic [11:0]      i_cfg_data
);
    import ffa_pkg::*;

    localparam int unsigned AW    = $clog2(HEAP_UNITS);
    localparam int unsigned SW    = AW + 1;
    localparam int unsigned UB    = $clog2(UNIT_BYTES);
    localparam int unsigned A_LIM = 2 * HEAP_UNITS + 2;
    localparam int unsigned F_LIM = HEAP_UNITS + 1;
    localparam int unsigned CW    = $clog2(A_LIM + 1);
    localparam int unsigned FW    = $clog2(F_LIM + 1);

    // sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_A_PRV  = 4'd1;  // read prev (rover) header
    localparam logic [3:0] S_A_PRVW = 4'd2;  // take prev size and first candidate
    localparam logic [3:0] S_A_RD   = 4'd3;  // read candidate header
    localparam logic [3:0] S_A_CHK  = 4'd4;  // size compare, unlink or split
    localparam logic [3:0] S_A_SPL  = 4'd5;  // write tail header
    localparam logic [3:0] S_A_GR   = 4'd6;  // grow check and new block header
    localparam logic [3:0] S_F_RD   = 4'd7;  // free walk read p
    localparam logic [3:0] S_F_CHK  = 4'd8;  // placement test
    localparam logic [3:0] S_F_BP   = 4'd9;  // read bp header
    localparam logic [3:0] S_F_NX   = 4'd10; // read nx header, take bp size
    localparam logic [3:0] S_F_MRG  = 4'd11; // write bp, merged with nx when adjacent
    localparam logic [3:0] S_F_WP   = 4'd12; // write p, merged with bp when adjacent
    localparam logic [3:0] S_OUT    = 4'd13;

    logic [3:0]    r_st, n_st;
    logic [11:0]   r_lim, r_min;
    logic          r_ready_list;
    logic [AW-1:0] r_rover;
    logic [AW:0]   r_brk;
    logic [SW-1:0] r_units;
    logic [AW-1:0] r_prev, r_now, r_p, r_bp, r_nx, r_nnx, r_bnext;
    logic [SW-1:0] r_bsz, r_psz;
    logic [CW-1:0] r_steps;
    logic [FW-1:0] r_fsteps;
    logic          r_growing;   // free walk launched by growth
    t_rsp          r_rsp;

    // memory port
    logic          m_we;
    logic [AW-1:0] m_wa, m_wn, m_ra;
    logic [SW-1:0] m_ws;
    logic [SW-1:0] m_rs;
    logic [AW-1:0] m_rn;

    ffa_hdr_mem #(.AW(AW), .SW(SW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (m_we),
        .i_waddr (m_wa),
        .i_wsize (m_ws),
        .i_wnext (m_wn),
        .i_raddr (m_ra),
        .o_rsize (m_rs),
        .o_rnext (m_rn)
    );

    // one beat in flight: input and config only taken while idle
    assign o_ready     = (r_st == S_IDLE);
    assign o_cfg_ready = (r_st == S_IDLE);
    assign o_valid     = (r_st == S_OUT);
    assign o_rsp       = r_rsp;

    // units = ceil(bytes/UNIT_BYTES)+1, clipped into memory width
    logic [16:0] w_units_full;
    assign w_units_full = 17'((({1'b0, i_req.alloc_bytes} + 17'(UNIT_BYTES - 1)) >> UB) + 17'd1);

    // free placement test, m_rn is the next link of p
    logic w_in_gap, w_wrap;
    assign w_in_gap = (r_bp > r_p) && (r_bp < m_rn);
    assign w_wrap   = (r_p >= m_rn) && ((r_bp > r_p) || (r_bp < m_rn));

    // growth size and limit test
    logic [AW+1:0] w_grow_num, w_grow_end;
    logic          w_grow_bad;
    assign w_grow_num = ((AW+2)'(r_units) < (AW+2)'(r_min)) ? (AW+2)'(r_min) : (AW+2)'(r_units);
    assign w_grow_end = (AW+2)'(r_brk) + w_grow_num;
    assign w_grow_bad = (w_grow_end > (AW+2)'(r_lim) + (AW+2)'(1))
                     || (w_grow_end > (AW+2)'(HEAP_UNITS));

    // merges, sums kept one bit wider so the arena end never aliases unit 0
    logic          w_bmerge, w_pmerge;
    logic [SW-1:0] w_bsz_new;
    logic [AW-1:0] w_bnext_new;
    assign w_bmerge    = ((AW+1)'(r_bp) + (AW+1)'(r_bsz)) == (AW+1)'(r_nx);
    assign w_bsz_new   = w_bmerge ? r_bsz + m_rs : r_bsz;
    assign w_bnext_new = w_bmerge ? m_rn : r_nx;
    assign w_pmerge    = ((AW+1)'(r_p) + (AW+1)'(r_psz)) == (AW+1)'(r_bp);

    // after a growth insert the walk restarts from rover, counted as one step
    logic       w_cont_fail;
    logic [3:0] w_cont_st;
    assign w_cont_fail = (r_steps >= CW'(A_LIM));
    assign w_cont_st   = w_cont_fail ? S_OUT : S_A_PRV;

    always_comb begin
        n_st = r_st;
        m_we = 1'b0;
        m_wa = '0;
        m_ws = '0;
        m_wn = '0;
        m_ra = r_now;
        unique case (r_st)
            S_IDLE: begin
                if (i_valid) begin
                    n_st = (i_req.cmd == CMD_ALLOC) ? S_A_PRV : S_F_RD;
                    // sentinel at unit 0: size zero, linked to itself
                    m_we = !r_ready_list;
                end
            end
            S_A_PRV: begin
                m_ra = r_prev;
                n_st = S_A_PRVW;
            end
            S_A_PRVW: n_st = S_A_RD;
            S_A_RD: begin
                m_ra = r_now;
                n_st = S_A_CHK;
            end
            S_A_CHK: begin
                if (m_rs >= r_units) begin
                    m_we = 1'b1;
                    if (m_rs == r_units) begin
                        // exact fit: unlink from prev
                        m_wa = r_prev;
                        m_ws = r_psz;
                        m_wn = m_rn;
                        n_st = S_OUT;
                    end else begin
                        // shrink and hand out the tail
                        m_wa = r_now;
                        m_ws = m_rs - r_units;
                        m_wn = m_rn;
                        n_st = S_A_SPL;
                    end
                end else if (r_now == r_rover) begin
                    n_st = S_A_GR;
                end else if (r_steps >= CW'(A_LIM)) begin
                    n_st = S_OUT;
                end else begin
                    n_st = S_A_RD;
                end
            end
            S_A_SPL: begin
                m_we = 1'b1;
                m_wa = r_nnx;
                m_ws = r_units;
                n_st = S_OUT;
            end
            S_A_GR: begin
                if (w_grow_bad) begin
                    n_st = S_OUT;
                end else begin
                    m_we = 1'b1;
                    m_wa = AW'(r_brk);
                    m_ws = SW'(w_grow_num);
                    n_st = S_F_RD;
                end
            end
            S_F_RD: begin
                m_ra = r_p;
                n_st = S_F_CHK;
            end
            S_F_CHK: begin
                if (w_in_gap || w_wrap) n_st = S_F_BP;
                else if (r_fsteps >= FW'(F_LIM)) n_st = r_growing ? w_cont_st : S_OUT;
                else n_st = S_F_RD;
            end
            S_F_BP: begin
                m_ra = r_bp;
                n_st = S_F_NX;
            end
            S_F_NX: begin
                m_ra = r_nx;
                n_st = S_F_MRG;
            end
            S_F_MRG: begin
                m_we = 1'b1;
                m_wa = r_bp;
                m_ws = w_bsz_new;
                m_wn = w_bnext_new;
                n_st = S_F_WP;
            end
            S_F_WP: begin
                m_we = 1'b1;
                m_wa = r_p;
                if (w_pmerge) begin
                    m_ws = r_psz + r_bsz;
                    m_wn = r_bnext;
                end else begin
                    m_ws = r_psz;
                    m_wn = r_bp;
                end
                n_st = r_growing ? w_cont_st : S_OUT;
            end
            S_OUT: if (i_ready) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    // control state with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st         <= S_IDLE;
            r_lim        <= HEAP_LIMIT_RST;
            r_min        <= MIN_GROW_RST;
            r_ready_list <= 1'b0;
            r_rover      <= '0;
            r_brk        <= (AW+1)'(1);
        end else begin
            r_st <= n_st;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == REG_HEAP_LIMIT) r_lim <= i_cfg_data;
                else r_min <= i_cfg_data;
            end
            if (r_st == S_IDLE && i_valid && !r_ready_list) r_ready_list <= 1'b1;
            if (r_st == S_A_CHK && m_rs >= r_units) r_rover <= r_prev;
            if (r_st == S_F_WP) r_rover <= r_p;
            if (r_st == S_A_GR && !w_grow_bad) r_brk <= (AW+1)'(w_grow_end);
        end
    end

    // walk datapath
    always_ff @(posedge i_clk) begin
        unique case (r_st)
            S_IDLE: begin
                r_steps   <= '0;
                r_fsteps  <= '0;
                r_growing <= 1'b0;
                r_units   <= (w_units_full > 17'(HEAP_UNITS)) ? '1 : SW'(w_units_full);
                r_prev    <= r_rover;
                r_p       <= r_rover;
                r_bp      <= AW'(AW'(i_req.block_address) - AW'(1));
            end
            S_A_PRVW: begin
                r_now <= m_rn;
                r_psz <= m_rs;
            end
            S_A_CHK: begin
                if (m_rs >= r_units) begin
                    if (m_rs == r_units) begin
                        r_rsp <= '{address: 12'(AW'(r_now + AW'(1))), fail: 1'b0};
                    end else begin
                        r_nnx <= AW'(r_now + AW'(m_rs - r_units));
                    end
                end else if (r_now == r_rover) begin
                    r_rsp <= r_rsp;
                end else if (r_steps >= CW'(A_LIM)) begin
                    r_rsp <= '{address: '0, fail: 1'b1};
                end else begin
                    r_steps <= r_steps + CW'(1);
                    r_prev  <= r_now;
                    r_psz   <= m_rs;
                    r_now   <= m_rn;
                end
            end
            S_A_SPL: r_rsp <= '{address: 12'(AW'(r_nnx + AW'(1))), fail: 1'b0};
            S_A_GR: begin
                if (w_grow_bad) begin
                    r_rsp <= '{address: '0, fail: 1'b1};
                end else begin
                    r_bp      <= AW'(r_brk);
                    r_p       <= r_rover;
                    r_fsteps  <= '0;
                    r_growing <= 1'b1;
                end
            end
            S_F_CHK: begin
                if (w_in_gap || w_wrap) begin
                    r_nx  <= m_rn;
                    r_psz <= m_rs;
                end else if (r_fsteps >= FW'(F_LIM)) begin
                    // walk too long: insert dropped
                    if (!r_growing) begin
                        r_rsp <= '{address: '0, fail: 1'b0};
                    end else if (w_cont_fail) begin
                        r_rsp <= '{address: '0, fail: 1'b1};
                    end else begin
                        r_growing <= 1'b0;
                        r_steps   <= r_steps + CW'(1);
                        r_prev    <= r_rover;
                    end
                end else begin
                    r_fsteps <= r_fsteps + FW'(1);
                    r_p      <= m_rn;
                end
            end
            S_F_NX: r_bsz <= m_rs;
            S_F_MRG: begin
                r_bsz   <= w_bsz_new;
                r_bnext <= w_bnext_new;
            end
            S_F_WP: begin
                if (!r_growing) begin
                    r_rsp <= '{address: '0, fail: 1'b0};
                end else if (w_cont_fail) begin
                    r_rsp <= '{address: '0, fail: 1'b1};
                end else begin
                    r_growing <= 1'b0;
                    r_steps   <= r_steps + CW'(1);
                    r_prev    <= r_p;
                end
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_valid_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("input ready while a response waits");
    a_rsp_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_rsp)))
        else $error("response beat changed while stalled");
    a_break_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_brk <= (AW+1)'(HEAP_UNITS))
        else $error("break past arena");
    a_fail_no_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.fail) |-> (o_rsp.address == '0))
        else $error("failed allocation with an address");
`endif
endmodule

[rtl/ffa_hdr_mem.sv]
module ffa_hdr_mem #(
    parameter int unsigned AW = 12,
    parameter int unsigned SW = 13
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [SW-1:0] i_wsize,
    input  logic [AW-1:0] i_wnext,
    input  logic [AW-1:0] i_raddr,
    output logic [SW-1:0] o_rsize,
    output logic [AW-1:0] o_rnext
);
    logic [SW+AW-1:0] r_mem [0:(1<<AW)-1];
    logic [SW+AW-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= {i_wsize, i_wnext};
        end
        r_rd <= r_mem[i_raddr];
    end

    assign o_rsize = r_rd[SW+AW-1:AW];
    assign o_rnext = r_rd[AW-1:0];
endmodule

[test/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ffa_pkg::*;

    localparam int unsigned UNITS      = 4096;
    localparam int unsigned UBYTES     = 16;
    localparam int unsigned CYCLE_CAP  = 100_000_000;
    localparam int unsigned DRAIN_WAIT = 40;

    // heap model plus the queue of outstanding responses
    class heap_scoreboard;
        int unsigned hsize [UNITS];
        int unsigned hnext [UNITS];
        int unsigned rover;
        int unsigned brk;
        bit          built;
        int unsigned limit_units;
        int unsigned grow_units;
        t_rsp        pending [$];
        int unsigned errors;

        function new();
            foreach (hsize[i]) begin
                hsize[i] = 0;
                hnext[i] = 0;
            end
            rover       = 0;
            brk         = 1;
            built       = 0;
            limit_units = HEAP_LIMIT_RST;
            grow_units  = MIN_GROW_RST;
            errors      = 0;
        endfunction

        function void set_reg(logic idx, logic [11:0] val);
            if (idx == REG_HEAP_LIMIT) limit_units = val;
            else grow_units = val;
        endfunction

        // address-ordered insert with merge on both sides
        function bit link_block(int unsigned bp);
            int unsigned p;
            int unsigned nx;
            int unsigned steps;
            p = rover;
            steps = 0;
            bp = bp % UNITS;
            forever begin
                nx = hnext[p];
                if (bp > p && bp < nx) break;
                if (p >= nx && (bp > p || bp < nx)) break;
                steps++;
                if (steps > UNITS + 1) return 0;
                p = nx;
            end
            nx = hnext[p];
            if (bp + hsize[bp] == nx) begin
                hsize[bp] += hsize[nx];
                hnext[bp] = hnext[nx];
            end else begin
                hnext[bp] = nx;
            end
            if (p + hsize[p] == bp) begin
                hsize[p] += hsize[bp];
                hnext[p] = hnext[bp];
            end else begin
                hnext[p] = bp;
            end
            rover = p;
            return 1;
        endfunction

        function bit extend_arena(int unsigned units);
            int unsigned num;
            int unsigned h;
            bit          ok;
            num = (units < grow_units) ? grow_units : units;
            h = brk;
            if (h + num > limit_units + 1 || h + num > UNITS) return 0;
            hsize[h] = num;
            hnext[h] = 0;
            brk = h + num;
            ok = link_block(h);
            return 1;
        endfunction

        function int unsigned first_fit(int unsigned nbytes);
            int unsigned units;
            int unsigned prev;
            int unsigned now;
            int unsigned steps;
            units = (nbytes + UBYTES - 1) / UBYTES + 1;
            prev = rover;
            now = hnext[prev];
            steps = 0;
            forever begin
                if (hsize[now] >= units) begin
                    if (hsize[now] == units) begin
                        hnext[prev] = hnext[now];
                    end else begin
                        hsize[now] -= units;
                        now = (now + hsize[now]) % UNITS;
                        hsize[now] = units;
                    end
                    rover = prev;
                    return now + 1;
                end
                if (now == rover) begin
                    if (!extend_arena(units)) return 0;
                    now = rover;
                end
                steps++;
                if (steps > 2 * UNITS + 2) return 0;
                prev = now;
                now = hnext[now];
            end
        endfunction

        // predicts the response to one accepted request, returns the address
        function logic [11:0] note_request(t_req r);
            t_rsp        e;
            int unsigned a;
            bit          ok;
            if (!built) begin
                hsize[0] = 0;
                hnext[0] = 0;
                rover = 0;
                built = 1;
            end
            if (r.cmd == CMD_ALLOC) begin
                a = first_fit(r.alloc_bytes);
                e.address = a[11:0];
                e.fail = (a == 0);
            end else begin
                ok = link_block(r.block_address + UNITS - 1);
                e.address = '0;
                e.fail = 1'b0;
            end
            pending.push_back(e);
            return e.address;
        endfunction

        function void check_response(t_rsp got);
            t_rsp e;
            if (pending.size() == 0) begin
                $display("%0t: response with none outstanding: addr %h fail %b",
                         $time, got.address, got.fail);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.address !== e.address) begin
                $display("%0t: address mismatch: expected %h actual %h",
                         $time, e.address, got.address);
                errors++;
            end
            if (got.fail !== e.fail) begin
                $display("%0t: fail flag mismatch: expected %b actual %b",
                         $time, e.fail, got.fail);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic        o_ready;
    t_req        i_req       = '0;
    logic        o_valid;
    logic        i_ready     = 1'b0;
    t_rsp        o_rsp;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = 1'b0;
    logic [11:0] i_cfg_data  = '0;

    heap_scoreboard sb = new();

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned cycles        = 0;
    logic [11:0] live_blocks [$];

    first_fit_free_list_allocator u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_req       (i_req),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_rsp       (o_rsp),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver back-pressure, redrawn every cycle
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // every response beat goes straight to the scoreboard
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) sb.check_response(o_rsp);
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("first_fit_free_list_allocator verification failed");
            $finish;
        end
    end

    // one request beat; valid is only dropped when a gap follows
    task automatic push_request(t_req r);
        logic [11:0] addr;
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_valid <= 1'b1;
        i_req   <= r;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        addr = sb.note_request(r);
        if (r.cmd == CMD_ALLOC && addr != 0) live_blocks.push_back(addr);
    endtask

    task automatic do_alloc(int unsigned nbytes);
        t_req r;
        r = '0;
        r.cmd = CMD_ALLOC;
        r.alloc_bytes = 16'(nbytes);
        r.block_address = 12'($urandom);
        push_request(r);
    endtask

    // frees only blocks handed out and not yet returned
    task automatic do_free(int unsigned pick);
        t_req r;
        r = '0;
        r.cmd = CMD_FREE;
        r.alloc_bytes = 16'($urandom);
        r.block_address = live_blocks[pick];
        live_blocks.delete(pick);
        push_request(r);
    endtask

    task automatic free_random();
        if (live_blocks.size() > 0) do_free($urandom_range(live_blocks.size() - 1));
        else do_alloc($urandom_range(64));
    endtask

    // wait out every response, then let the block settle
    task automatic drain();
        @(posedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [11:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_reg(idx, val);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // mostly small requests, the odd huge one, frees keep the heap churning
    task automatic random_traffic(int unsigned n);
        int unsigned sel;
        repeat (n) begin
            sel = $urandom_range(99);
            if (sel < 40) free_random();
            else if (sel < 85) do_alloc($urandom_range(300));
            else if (sel < 97) do_alloc($urandom_range(4000));
            else do_alloc($urandom_range(65535));
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // minimum growth of one unit so exact fits and splits are easy to hit
        write_reg(REG_HEAP_LIMIT, 12'd4095);
        write_reg(REG_MIN_GROW, 12'd1);
        send_idle_pct = 22;
        recv_idle_pct = 69;

        do_alloc(0);          // first request builds the sentinel, header only
        do_alloc(65535);      // far beyond the arena, must fail
        do_alloc(16);
        do_alloc(17);
        do_alloc(1);
        do_alloc(32);
        do_free(1);           // middle block back, no neighbours free
        do_alloc(17);         // one unit more than the freed block holds, so it does not fit there
        do_free(0);
        do_free(0);           // merges with the preceding free block
        do_alloc(48);
        do_alloc(15);
        do_free(live_blocks.size() - 1);
        do_free(0);
        do_alloc(4000);
        do_alloc(65520);
        drain();

        // larger grow step: later allocations split growth blocks from the tail
        write_reg(REG_MIN_GROW, 12'd1024);
        random_traffic(300);
        drain();

        // limit set to one unit: any growth fails
        write_reg(REG_HEAP_LIMIT, 12'd1);
        write_reg(REG_MIN_GROW, 12'd4095);
        do_alloc(0);
        do_alloc(65535);
        random_traffic(40);
        drain();

        // full arena, minimum growth of one unit, idling swapped
        write_reg(REG_HEAP_LIMIT, 12'd4095);
        write_reg(REG_MIN_GROW, 12'd1);
        send_idle_pct = 69;
        recv_idle_pct = 22;
        random_traffic(300);
        drain();

        // mid limit, no idling on either side
        write_reg(REG_HEAP_LIMIT, 12'd2048);
        write_reg(REG_MIN_GROW, 12'd16);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_traffic(350);
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("first_fit_free_list_allocator verification clean");
        else
            $display("first_fit_free_list_allocator verification failed");
        $finish;
    end

endmodule
